FILE: rtl/core/lcsr_pkg.sv
// Shared types, constants and helpers for the character LCD shadow refresh block.
// Used by lcsr_store, lcsr_fmt, lcsr_seq and char_lcd_shadow_refresh; depends on nothing.
package lcsr_pkg;

	localparam int LINE_CELLS = 16;
	localparam int LINE_COUNT = 2;
	localparam int DEPTH      = LINE_CELLS * LINE_COUNT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int INIT_LEN   = 6;
	localparam int STEP_W     = 3;

	// item modes
	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_COMMIT = 2'd2;
	localparam logic [1:0] MODE_INIT   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_BACKLIGHT  = 2'd0;
	localparam logic [1:0] REG_DISPLAY_ON = 2'd1;
	localparam logic [1:0] REG_CLEAR      = 2'd2;

	localparam logic [7:0] DISPLAY_ON_RST = 8'h0c;
	localparam logic [7:0] CLEAR_RST      = 8'h01;

	// LCD commands and characters
	localparam logic [7:0] CMD_WAKE0    = 8'h33;
	localparam logic [7:0] CMD_WAKE1    = 8'h32;
	localparam logic [7:0] CMD_FUNC_SET = 8'h28;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_CURSOR   = 8'h80;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	typedef struct packed {
		logic              fw_en;
		logic [ADDR_W-1:0] fw_addr;
		logic [7:0]        fw_data;
		logic              sw_en;
		logic [ADDR_W-1:0] sw_addr;
		logic [7:0]        sw_data;
		logic [ADDR_W-1:0] rd_addr;
	} store_req_t;

	typedef struct packed {
		logic              vld;
		logic              scan;
		logic              from_mem;
		logic [7:0]        cmd;
		logic              is_data;
		logic              last;
		logic              line;
		logic [ADDR_W-1:0] addr;
	} op_t;

	typedef struct packed {
		logic       en;
		logic [7:0] lcd_byte;
		logic       is_data;
		logic       last;
	} fmt_req_t;

	function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] step,
		input logic [7:0] disp_code, input logic [7:0] clr_code);
		logic [7:0] cmd;
		unique case (step)
			3'd0:    cmd = CMD_WAKE0;
			3'd1:    cmd = CMD_WAKE1;
			3'd2:    cmd = CMD_FUNC_SET;
			3'd3:    cmd = disp_code;
			3'd4:    cmd = CMD_ENTRY;
			default: cmd = clr_code;
		endcase
		return cmd;
	endfunction

	function automatic logic [ADDR_W-1:0] line_base(input logic line);
		return line ? ADDR_W'(LINE_CELLS) : '0;
	endfunction

endpackage

FILE: rtl/core/char_lcd_shadow_refresh.sv
// Top level of the character LCD shadow refresh controller: config registers and wiring.
// Depends on lcsr_pkg, lcsr_store, lcsr_fmt and lcsr_seq.
//
// channel   direction  handshake                  payload
// command   in         start, accepted when !busy mode, row, column, char_code
// result    out        result_strobe, one cycle   exp_byte0..3, is_data, lcd_byte, last
// config    in         cfg_we                     cfg_index, cfg_data
//
// A write-cell transaction never raises busy. Clear holds busy while writing every store
// entry, one per cycle. Commit: a compare scan of all DEPTH entries, settle and pick,
// then 6 init results if init is pending, then 17 results per changed line, one per cycle;
// init alone gives 6. The single store read port sets the pace. busy drops as the final
// result shows. Reset clears the stores to zero through valid bits, so no clearing pass
// is needed. The receiver cannot stall: results are presented for one cycle each.
module char_lcd_shadow_refresh (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic       row,
	input  logic [3:0] column,
	input  logic [7:0] char_code,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       result_strobe,
	output logic [7:0] exp_byte0,
	output logic [7:0] exp_byte1,
	output logic [7:0] exp_byte2,
	output logic [7:0] exp_byte3,
	output logic       is_data,
	output logic [7:0] lcd_byte,
	output logic       last
);

	logic                 backlight_q;
	logic [7:0]           disp_code_q;
	logic [7:0]           clr_code_q;
	logic [7:0]           frame_rd;
	logic [7:0]           shown_rd;
	lcsr_pkg::store_req_t store_req;
	lcsr_pkg::fmt_req_t   fmt_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
			disp_code_q <= lcsr_pkg::DISPLAY_ON_RST;
			clr_code_q  <= lcsr_pkg::CLEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcsr_pkg::REG_BACKLIGHT:  backlight_q <= cfg_data[0];
				lcsr_pkg::REG_DISPLAY_ON: disp_code_q <= cfg_data;
				lcsr_pkg::REG_CLEAR:      clr_code_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lcsr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.row       (row),
		.column    (column),
		.char_code (char_code),
		.disp_code (disp_code_q),
		.clr_code  (clr_code_q),
		.frame_rd  (frame_rd),
		.shown_rd  (shown_rd),
		.busy      (busy),
		.store_req (store_req),
		.fmt_req   (fmt_req)
	);

	lcsr_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (store_req),
		.frame_rd (frame_rd),
		.shown_rd (shown_rd)
	);

	lcsr_fmt u_fmt (
		.clk           (clk),
		.arst_n        (arst_n),
		.backlight     (backlight_q),
		.req           (fmt_req),
		.result_strobe (result_strobe),
		.exp_byte0     (exp_byte0),
		.exp_byte1     (exp_byte1),
		.exp_byte2     (exp_byte2),
		.exp_byte3     (exp_byte3),
		.is_data       (is_data),
		.lcd_byte      (lcd_byte),
		.last          (last)
	);

`ifndef SYNTHESIS
	// a result is only produced while a transaction is in progress
	a_strobe_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without a transaction in progress");

	// the final result of a run is never followed directly by another result
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result right after the final result of a run");

	// character data always follows a cursor command or more data, back to back
	a_data_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && is_data) |-> $past(result_strobe))
		else $error("data result not preceded by a result");
`endif

endmodule

FILE: rtl/core/lcsr_store.sv
// Frame store and shown store: two memories with registered read and per-entry valid bits.
// Depends on lcsr_pkg.
module lcsr_store (
	input  logic                clk,
	input  logic                arst_n,
	input  lcsr_pkg::store_req_t req,
	output logic [7:0]          frame_rd,
	output logic [7:0]          shown_rd
);

	logic [7:0]                 fr_mem_q [lcsr_pkg::DEPTH];
	logic [7:0]                 sh_mem_q [lcsr_pkg::DEPTH];
	logic [lcsr_pkg::DEPTH-1:0] fr_vld_q;
	logic [lcsr_pkg::DEPTH-1:0] sh_vld_q;
	logic [7:0]                 fr_rd_q;
	logic [7:0]                 sh_rd_q;
	logic                       fr_ok_q;
	logic                       sh_ok_q;

	always_ff @(posedge clk) begin
		if (req.fw_en) begin
			fr_mem_q[req.fw_addr] <= req.fw_data;
		end
		if (req.sw_en) begin
			sh_mem_q[req.sw_addr] <= req.sw_data;
		end
		fr_rd_q <= fr_mem_q[req.rd_addr];
		sh_rd_q <= sh_mem_q[req.rd_addr];
	end

	// never-written entries read as zero, the reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_q <= '0;
			sh_vld_q <= '0;
			fr_ok_q  <= 1'b0;
			sh_ok_q  <= 1'b0;
		end else begin
			if (req.fw_en) begin
				fr_vld_q[req.fw_addr] <= 1'b1;
			end
			if (req.sw_en) begin
				sh_vld_q[req.sw_addr] <= 1'b1;
			end
			fr_ok_q <= fr_vld_q[req.rd_addr];
			sh_ok_q <= sh_vld_q[req.rd_addr];
		end
	end

	assign frame_rd = fr_ok_q ? fr_rd_q : 8'h00;
	assign shown_rd = sh_ok_q ? sh_rd_q : 8'h00;

endmodule

FILE: rtl/core/lcsr_fmt.sv
// Shared nibble formatter: splits one LCD byte into four expander bytes, registered result.
// Depends on lcsr_pkg.
module lcsr_fmt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               backlight,
	input  lcsr_pkg::fmt_req_t req,
	output logic               result_strobe,
	output logic [7:0]         exp_byte0,
	output logic [7:0]         exp_byte1,
	output logic [7:0]         exp_byte2,
	output logic [7:0]         exp_byte3,
	output logic               is_data,
	output logic [7:0]         lcd_byte,
	output logic               last
);

	logic       strobe_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic [7:0] b2_q;
	logic [7:0] b3_q;
	logic       is_data_q;
	logic [7:0] lcd_byte_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= req.en;
		end
	end

	// expander byte: {nibble, backlight, enable, rw = 0, rs}
	always_ff @(posedge clk) begin
		if (req.en) begin
			b0_q       <= {req.lcd_byte[7:4], backlight, 1'b1, 1'b0, req.is_data};
			b1_q       <= {req.lcd_byte[7:4], backlight, 1'b0, 1'b0, req.is_data};
			b2_q       <= {req.lcd_byte[3:0], backlight, 1'b1, 1'b0, req.is_data};
			b3_q       <= {req.lcd_byte[3:0], backlight, 1'b0, 1'b0, req.is_data};
			is_data_q  <= req.is_data;
			lcd_byte_q <= req.lcd_byte;
			last_q     <= req.last;
		end
	end

	assign result_strobe = strobe_q;
	assign exp_byte0     = b0_q;
	assign exp_byte1     = b1_q;
	assign exp_byte2     = b2_q;
	assign exp_byte3     = b3_q;
	assign is_data       = is_data_q;
	assign lcd_byte      = lcd_byte_q;
	assign last          = last_q;

endmodule

FILE: rtl/core/lcsr_seq.sv
// Sequencer: clear sweep, line compare scan, init sequence and line refresh, one op per cycle.
// Depends on lcsr_pkg; drives lcsr_store and lcsr_fmt.
module lcsr_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           mode,
	input  logic                 row,
	input  logic [3:0]           column,
	input  logic [7:0]           char_code,
	input  logic [7:0]           disp_code,
	input  logic [7:0]           clr_code,
	input  logic [7:0]           frame_rd,
	input  logic [7:0]           shown_rd,
	output logic                 busy,
	output lcsr_pkg::store_req_t store_req,
	output lcsr_pkg::fmt_req_t   fmt_req
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLR    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_SETTLE = 3'd3;
	localparam logic [2:0] ST_PICK   = 3'd4;
	localparam logic [2:0] ST_INIT   = 3'd5;
	localparam logic [2:0] ST_CURS   = 3'd6;
	localparam logic [2:0] ST_DATA   = 3'd7;

	localparam int AW = lcsr_pkg::ADDR_W;

	logic [2:0]                      state_q, state_d;
	logic [AW-1:0]                   idx_q, idx_d;
	logic                            line_q, line_d;
	logic [lcsr_pkg::STEP_W-1:0]     step_q, step_d;
	logic                            lines_q, lines_d;
	logic                            init_done_q, init_d;
	logic [lcsr_pkg::LINE_COUNT-1:0] diff_q;
	lcsr_pkg::op_t                   op_s1, op_d;

	logic accept;
	logic wr_ok;
	logic diff_clr;
	logic clr_wr;
	logic any_diff;
	logic first_line;
	logic more_after;
	logic line_end;
	logic sweep_end;
	logic init_end;

	assign busy       = (state_q != ST_IDLE) || op_s1.vld;
	assign accept     = start && !busy;
	assign wr_ok      = (int'(row) < lcsr_pkg::LINE_COUNT) && (int'(column) < lcsr_pkg::LINE_CELLS);
	assign any_diff   = |diff_q;
	assign first_line = !diff_q[0];
	assign more_after = (lcsr_pkg::LINE_COUNT > 1) && !line_q && diff_q[lcsr_pkg::LINE_COUNT-1];
	assign line_end   = idx_q == (lcsr_pkg::line_base(line_q) + AW'(lcsr_pkg::LINE_CELLS - 1));
	assign sweep_end  = idx_q == AW'(lcsr_pkg::DEPTH - 1);
	assign init_end   = step_q == lcsr_pkg::STEP_W'(lcsr_pkg::INIT_LEN - 1);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		line_d   = line_q;
		step_d   = step_q;
		lines_d  = lines_q;
		init_d   = init_done_q;
		diff_clr = 1'b0;
		clr_wr   = 1'b0;
		op_d     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						lcsr_pkg::MODE_WRITE: begin
						end
						lcsr_pkg::MODE_CLEAR: begin
							state_d = ST_CLR;
							idx_d   = '0;
						end
						lcsr_pkg::MODE_COMMIT: begin
							state_d  = ST_SCAN;
							idx_d    = '0;
							diff_clr = 1'b1;
						end
						lcsr_pkg::MODE_INIT: begin
							if (!init_done_q) begin
								state_d = ST_INIT;
								step_d  = '0;
								lines_d = 1'b0;
								init_d  = 1'b1;
							end
						end
					endcase
				end
			end
			ST_CLR: begin
				clr_wr = 1'b1;
				idx_d  = idx_q + AW'(1);
				if (sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				op_d.vld  = 1'b1;
				op_d.scan = 1'b1;
				op_d.addr = idx_q;
				op_d.line = int'(idx_q) >= lcsr_pkg::LINE_CELLS;
				idx_d     = idx_q + AW'(1);
				if (sweep_end) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				// last compare lands in diff_q this cycle
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (!init_done_q) begin
					state_d = ST_INIT;
					step_d  = '0;
					lines_d = 1'b1;
					init_d  = 1'b1;
				end else if (any_diff) begin
					state_d = ST_CURS;
					line_d  = first_line;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_INIT: begin
				op_d.vld  = 1'b1;
				op_d.cmd  = lcsr_pkg::init_cmd(step_q, disp_code, clr_code);
				op_d.last = init_end && (!lines_q || !any_diff);
				step_d    = step_q + lcsr_pkg::STEP_W'(1);
				if (init_end) begin
					if (lines_q && any_diff) begin
						state_d = ST_CURS;
						line_d  = first_line;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CURS: begin
				op_d.vld = 1'b1;
				op_d.cmd = lcsr_pkg::CMD_CURSOR | {1'b0, line_q, 6'b0};
				state_d  = ST_DATA;
				idx_d    = lcsr_pkg::line_base(line_q);
			end
			ST_DATA: begin
				op_d.vld      = 1'b1;
				op_d.from_mem = 1'b1;
				op_d.is_data  = 1'b1;
				op_d.addr     = idx_q;
				op_d.last     = line_end && !more_after;
				idx_d         = idx_q + AW'(1);
				if (line_end) begin
					if (more_after) begin
						state_d = ST_CURS;
						line_d  = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			line_q      <= 1'b0;
			step_q      <= '0;
			lines_q     <= 1'b0;
			init_done_q <= 1'b0;
			op_s1       <= '0;
			diff_q      <= '0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			line_q      <= line_d;
			step_q      <= step_d;
			lines_q     <= lines_d;
			init_done_q <= init_d;
			op_s1       <= op_d;
			if (diff_clr) begin
				diff_q <= '0;
			end else if (op_s1.vld && op_s1.scan && (frame_rd != shown_rd)) begin
				diff_q[op_s1.line] <= 1'b1;
			end
		end
	end

	// second stage: read data is back; copy frame cell into shown store as it goes out
	always_comb begin
		fmt_req.en       = op_s1.vld && !op_s1.scan;
		fmt_req.lcd_byte = op_s1.from_mem ? frame_rd : op_s1.cmd;
		fmt_req.is_data  = op_s1.is_data;
		fmt_req.last     = op_s1.last;

		store_req.rd_addr = idx_q;
		store_req.fw_en   = clr_wr || (accept && (mode == lcsr_pkg::MODE_WRITE) && wr_ok);
		store_req.fw_addr = clr_wr ? idx_q : (lcsr_pkg::line_base(row) + AW'(column));
		store_req.fw_data = clr_wr ? lcsr_pkg::CHAR_SPACE : char_code;
		store_req.sw_en   = clr_wr || (op_s1.vld && op_s1.from_mem);
		store_req.sw_addr = clr_wr ? idx_q : op_s1.addr;
		store_req.sw_data = clr_wr ? lcsr_pkg::CHAR_SPACE : frame_rd;
	end

endmodule

FILE: verif/char_lcd_shadow_refresh_chk.sv
`timescale 1ns / 1ps
// Scoreboard for char_lcd_shadow_refresh. It tracks the frame and shown stores and the registers,
// predicts every LCD transfer and compares it with the result port. Depends on lcsr_pkg.
module char_lcd_shadow_refresh_chk
	import lcsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] mode,
	input  logic       row,
	input  logic [3:0] column,
	input  logic [7:0] char_code,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       result_strobe,
	input  logic [7:0] exp_byte0,
	input  logic [7:0] exp_byte1,
	input  logic [7:0] exp_byte2,
	input  logic [7:0] exp_byte3,
	input  logic       is_data,
	input  logic [7:0] lcd_byte,
	input  logic       last,
	output int         fail_count,
	output int         pending
);

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [7:0] hi_en;
		logic [7:0] hi_dis;
		logic [7:0] lo_en;
		logic [7:0] lo_dis;
		logic       rs;
		logic [7:0] code;
		logic       last_flag;
	} lcd_xfer_t;

	logic [7:0] frame_cells [DEPTH];
	logic [7:0] shown_cells [DEPTH];
	logic       init_sent;
	logic       backlight;
	logic [7:0] disp_on_cmd;
	logic [7:0] clear_cmd;
	lcd_xfer_t  lcd_xfers_due [$];

	// expander byte: nibble, backlight, enable, unused, register select
	function automatic lcd_xfer_t lcd_xfer(input logic [7:0] code, input logic rs);
		lcd_xfer_t x;
		x.hi_en     = {code[7:4], backlight, 1'b1, 1'b0, rs};
		x.hi_dis    = {code[7:4], backlight, 1'b0, 1'b0, rs};
		x.lo_en     = {code[3:0], backlight, 1'b1, 1'b0, rs};
		x.lo_dis    = {code[3:0], backlight, 1'b0, 1'b0, rs};
		x.rs        = rs;
		x.code      = code;
		x.last_flag = 1'b0;
		return x;
	endfunction

	task automatic queue_byte(input logic [7:0] code, input logic rs);
		lcd_xfers_due.push_back(lcd_xfer(code, rs));
	endtask

	// init runs once after reset, on the first commit or init transaction
	task automatic queue_init();
		if (!init_sent) begin
			init_sent = 1'b1;
			queue_byte(CMD_WAKE0, 1'b0);
			queue_byte(CMD_WAKE1, 1'b0);
			queue_byte(CMD_FUNC_SET, 1'b0);
			queue_byte(disp_on_cmd, 1'b0);
			queue_byte(CMD_ENTRY, 1'b0);
			queue_byte(clear_cmd, 1'b0);
		end
	endtask

	task automatic predict_transfers(input logic [1:0] op, input logic line_sel,
		input logic [3:0] col, input logic [7:0] code);
		int        first;
		int        base;
		logic      differs;
		lcd_xfer_t tail;
		first = lcd_xfers_due.size();
		case (op)
			MODE_WRITE: begin
				if (int'(line_sel) < LINE_COUNT && int'(col) < LINE_CELLS)
					frame_cells[int'(line_sel) * LINE_CELLS + int'(col)] = code;
			end
			MODE_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) begin
					frame_cells[i] = CHAR_SPACE;
					shown_cells[i] = CHAR_SPACE;
				end
			end
			MODE_COMMIT: begin
				queue_init();
				for (int ln = 0; ln < LINE_COUNT; ln++) begin
					base = ln * LINE_CELLS;
					differs = 1'b0;
					for (int c = 0; c < LINE_CELLS; c++)
						if (frame_cells[base + c] !== shown_cells[base + c])
							differs = 1'b1;
					if (differs) begin
						for (int c = 0; c < LINE_CELLS; c++)
							shown_cells[base + c] = frame_cells[base + c];
						queue_byte(CMD_CURSOR | (8'(ln % 2) << 6), 1'b0);
						for (int c = 0; c < LINE_CELLS; c++)
							queue_byte(shown_cells[base + c], 1'b1);
					end
				end
			end
			default: begin
				queue_init();
			end
		endcase
		if (lcd_xfers_due.size() > first) begin
			tail = lcd_xfers_due.pop_back();
			tail.last_flag = 1'b1;
			lcd_xfers_due.push_back(tail);
		end
	endtask

	task automatic check_transfer();
		lcd_xfer_t want;
		lcd_xfer_t got;
		got.hi_en     = exp_byte0;
		got.hi_dis    = exp_byte1;
		got.lo_en     = exp_byte2;
		got.lo_dis    = exp_byte3;
		got.rs        = is_data;
		got.code      = lcd_byte;
		got.last_flag = last;
		if (lcd_xfers_due.size() == 0) begin
			if (fail_count < REPORT_MAX)
				$display("%0t unexpected transfer: lcd %h rs %b", $realtime, lcd_byte, is_data);
			fail_count++;
		end else begin
			want = lcd_xfers_due.pop_front();
			if (got !== want) begin
				if (fail_count < REPORT_MAX) begin
					$display("%0t mismatch exp: %h %h %h %h rs %b lcd %h last %b", $realtime,
						want.hi_en, want.hi_dis, want.lo_en, want.lo_dis, want.rs, want.code,
						want.last_flag);
					$display("%0t mismatch act: %h %h %h %h rs %b lcd %h last %b", $realtime,
						got.hi_en, got.hi_dis, got.lo_en, got.lo_dis, got.rs, got.code,
						got.last_flag);
				end
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				frame_cells[i] = 8'h00;
				shown_cells[i] = 8'h00;
			end
			init_sent = 1'b0;
			backlight = 1'b1;
			disp_on_cmd = DISPLAY_ON_RST;
			clear_cmd = CLEAR_RST;
			lcd_xfers_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// results of an earlier transaction go first: one may end as the next is taken
			if (result_strobe)
				check_transfer();
			if (cfg_we) begin
				case (cfg_index)
					REG_BACKLIGHT:  backlight = cfg_data[0];
					REG_DISPLAY_ON: disp_on_cmd = cfg_data;
					REG_CLEAR:      clear_cmd = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				predict_transfers(mode, row, column, char_code);
			pending = lcd_xfers_due.size();
		end
	end

endmodule

FILE: verif/char_lcd_shadow_refresh_tb.sv
`timescale 1ns / 1ps
// Top of the char_lcd_shadow_refresh testbench: clock, reset, command and register stimulus,
// stall watchdog and verdict. Depends on lcsr_pkg, the block and char_lcd_shadow_refresh_chk.
module char_lcd_shadow_refresh_tb;
	import lcsr_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 5;
	localparam int PHASE_ITEMS   = 50;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] mode = MODE_WRITE;
	logic       row = 1'b0;
	logic [3:0] column = 4'd0;
	logic [7:0] char_code = 8'h00;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_BACKLIGHT;
	logic [7:0] cfg_data = 8'h00;
	logic       result_strobe;
	logic [7:0] exp_byte0;
	logic [7:0] exp_byte1;
	logic [7:0] exp_byte2;
	logic [7:0] exp_byte3;
	logic       is_data;
	logic [7:0] lcd_byte;
	logic       last;
	int         fail_count;
	int         pending;
	int         taken_count;
	int         stall_cycles;
	bit         no_idle = 1'b0;

	always #5 clk = ~clk;

	char_lcd_shadow_refresh dut (.*);

	char_lcd_shadow_refresh_chk chk (.*);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_count <= 0;
			stall_cycles <= 0;
		end else begin
			if (start && !busy)
				taken_count <= taken_count + 1;
			if ((start && !busy) || result_strobe || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 45)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	// start stays high into the next command when gap is zero
	task automatic send_cmd(input logic [1:0] op, input logic line_sel, input logic [3:0] col,
		input logic [7:0] code, input int gap);
		int prev;
		prev = taken_count;
		mode = op;
		row = line_sel;
		column = col;
		char_code = code;
		start = 1'b1;
		do @(negedge clk); while (taken_count == prev);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// clear and empty commits give no result, so pad past the longest silent run
	task automatic settle();
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic write_regs(input logic bl, input logic [7:0] disp, input logic [7:0] clr);
		cfg_we = 1'b1;
		cfg_index = REG_BACKLIGHT;
		cfg_data = {7'd0, bl};
		@(negedge clk);
		cfg_index = REG_DISPLAY_ON;
		cfg_data = disp;
		@(negedge clk);
		cfg_index = REG_CLEAR;
		cfg_data = clr;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic [1:0] op;
		logic [7:0] ch;
		int         roll;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// init content is only visible once, so set it before the first init
		write_regs(1'b0, 8'hff, 8'h00);

		// stores equal after reset: commit gives init only
		send_cmd(MODE_COMMIT, 1'b0, 4'd0, 8'h00, gap_len());
		send_cmd(MODE_INIT, 1'b1, 4'd15, 8'hff, gap_len());
		send_cmd(MODE_COMMIT, 1'b1, 4'd15, 8'hff, gap_len());
		send_cmd(MODE_WRITE, 1'b0, 4'd0, 8'hff, gap_len());
		send_cmd(MODE_WRITE, 1'b1, 4'd15, 8'h00, gap_len());
		send_cmd(MODE_COMMIT, 1'b0, 4'd3, 8'h12, gap_len());
		send_cmd(MODE_WRITE, 1'b1, 4'd15, 8'h5a, gap_len());
		send_cmd(MODE_WRITE, 1'b0, 4'd15, 8'h80, gap_len());
		send_cmd(MODE_WRITE, 1'b1, 4'd0, 8'h01, gap_len());
		send_cmd(MODE_COMMIT, 1'b1, 4'd8, 8'hc3, gap_len());
		send_cmd(MODE_CLEAR, 1'b1, 4'd9, 8'h33, gap_len());
		send_cmd(MODE_COMMIT, 1'b0, 4'd0, 8'h00, gap_len());
		send_cmd(MODE_WRITE, 1'b0, 4'd7, CHAR_SPACE, gap_len());
		send_cmd(MODE_COMMIT, 1'b0, 4'd7, 8'hff, gap_len());
		send_cmd(MODE_WRITE, 1'b1, 4'd10, 8'h7f, gap_len());
		send_cmd(MODE_COMMIT, 1'b1, 4'd10, 8'h7f, gap_len());
		send_cmd(MODE_INIT, 1'b0, 4'd5, 8'haa, gap_len());

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: write_regs(1'b1, 8'h00, 8'hff);
				1: write_regs(1'b0, 8'h5a, 8'ha5);
				default: write_regs(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
			no_idle = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 68)
					op = MODE_WRITE;
				else if (roll < 86)
					op = MODE_COMMIT;
				else if (roll < 93)
					op = MODE_CLEAR;
				else
					op = MODE_INIT;
				// spaces and zeros let lines fall back into step with the shown store
				roll = $urandom_range(0, 15);
				if (roll == 0)
					ch = 8'h00;
				else if (roll < 3)
					ch = CHAR_SPACE;
				else
					ch = 8'($urandom_range(0, 255));
				send_cmd(op, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), ch, gap_len());
			end
		end
		settle();

		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/lcsr_pkg.sv
rtl/core/lcsr_store.sv
rtl/core/lcsr_fmt.sv
rtl/core/lcsr_seq.sv
rtl/core/char_lcd_shadow_refresh.sv
verif/char_lcd_shadow_refresh_chk.sv
verif/char_lcd_shadow_refresh_tb.sv
